>>> rtl/kmeans_color_palette_engine_top_defines.svh
// Assertion macros for the palette engine checker.
`ifndef KMEANS_COLOR_PALETTE_ENGINE_TOP_DEFINES_SVH
`define KMEANS_COLOR_PALETTE_ENGINE_TOP_DEFINES_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define KCP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kcp check failed");
// Asserts that an antecedent implies a consequent in the next cycle.
`define KCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kcp check failed");
`endif

>>> rtl/kcp_pkg.sv
// ----------------------------------------------------------------------------
// kcp_pkg
// Types and constants shared by the palette engine modules.
// ----------------------------------------------------------------------------
`default_nettype none
package kcp_pkg;
    localparam int MaxCenters = 16;
    localparam int IdxW = $clog2(MaxCenters);
    localparam int MaxPixels = 65536;
    localparam int CntW = $clog2(MaxPixels) + 1;
    localparam int SumW = CntW + 8;
    localparam int CenW = 16;
    localparam int DistW = 34;
    localparam int QuotW = SumW + 8;

    localparam logic [1:0] ModeLoad = 2'd0;
    localparam logic [1:0] ModePixel = 2'd1;
    localparam logic [1:0] ModeUpdate = 2'd2;
    localparam logic [1:0] ModeRead = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] slot;
        logic [7:0] pixel_y;
        logic [7:0] pixel_cb;
        logic [7:0] pixel_cr;
    } in_item_t;

    typedef struct packed {
        logic [3:0] cluster_index;
        logic [33:0] min_distance_sq;
        logic [7:0] center_y;
        logic [7:0] center_cb;
        logic [7:0] center_cr;
        logic was_empty;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic dist_start;
        logic dist_step;
        logic accumulate;
        logic div_start;
        logic div_step;
        logic update_write;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic last_center;
        logic div_last;
        logic count_zero;
    } status_t;

    function automatic logic [7:0] round_center(input logic [CenW-1:0] c);
        logic [CenW:0] r;
        r = {1'b0, c} + (CenW+1)'(128);
        return (r[CenW:8] > 9'd255) ? 8'd255 : r[15:8];
    endfunction
endpackage
`default_nettype wire

>>> rtl/kcp_ctrl.sv
// ----------------------------------------------------------------------------
// kcp_ctrl
// Sequencer for the palette engine: steps the search and the divider.
// ----------------------------------------------------------------------------
`default_nettype none
module kcp_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  kcp_pkg::status_t     status,
    output kcp_pkg::cmd_t        cmd
);
    import kcp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIST   = 7'b0000010,
        S_ACC    = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_WRITE  = 7'b0010000,
        S_OUT    = 7'b0100000,
        S_STORE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                priority if (status.mode == ModePixel)
                begin
                    cmd.dist_start = 1'b1;
                    state_next = S_DIST;
                end
                else if (status.mode == ModeUpdate && !status.count_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.update_write = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_DIST:
            begin
                cmd.dist_step = 1'b1;
                if (status.last_center)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next = S_OUT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.update_write = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/kcp_datapath.sv
// ----------------------------------------------------------------------------
// kcp_datapath
// Center and accumulator storage, distance unit and restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module kcp_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  kcp_pkg::in_item_t      in_item,
    input  wire logic [4:0]        active_centers,
    input  kcp_pkg::cmd_t          cmd,
    output kcp_pkg::status_t       status,
    output kcp_pkg::out_item_t     out_item
);
    import kcp_pkg::*;

    logic [CenW-1:0] cen_reg [3][MaxCenters];
    logic [SumW-1:0] sum_reg [3][MaxCenters];
    logic [CntW-1:0] cnt_reg [MaxCenters];

    in_item_t        item_reg;
    logic [IdxW-1:0] idx_reg;
    logic [IdxW-1:0] best_reg;
    logic [DistW-1:0] best_d_reg;
    logic [IdxW:0]   lim;
    logic [DistW-1:0] d_sum;
    logic [17:0]     sq [3];
    logic [7:0]      pix [3];
    logic [CenW-1:0] cur_cen [3];

    logic [QuotW-1:0] num_reg [3];
    logic [QuotW-1:0] quo_reg [3];
    logic [CntW:0]    rem_reg [3];
    logic [5:0]       bit_reg;
    logic [CntW-1:0]  n_cnt;
    logic [CenW-1:0]  new_cen [3];
    logic             empty_reg;
    out_item_t        res_reg;

    assign pix[0] = item_reg.pixel_y;
    assign pix[1] = item_reg.pixel_cb;
    assign pix[2] = item_reg.pixel_cr;
    assign n_cnt = cnt_reg[item_reg.slot];

    always_comb
    begin
        if (active_centers == 5'd0)
        begin
            lim = (IdxW+1)'(1);
        end
        else if (active_centers > 5'(MaxCenters))
        begin
            lim = (IdxW+1)'(MaxCenters);
        end
        else
        begin
            lim = active_centers;
        end
    end

    always_comb
    begin
        logic [CenW:0] p;
        logic [CenW:0] c;
        logic [CenW:0] d;
        for (int k = 0; k < 3; k++)
        begin
            p = {1'b0, pix[k], 8'd0};
            c = {1'b0, cen_reg[k][idx_reg]};
            d = (p >= c) ? p - c : c - p;
            sq[k] = '0;
            cur_cen[k] = cen_reg[k][item_reg.slot];
            sq[k] = 18'(d);
        end
        d_sum = DistW'(sq[0]) * DistW'(sq[0]) + DistW'(sq[1]) * DistW'(sq[1])
              + DistW'(sq[2]) * DistW'(sq[2]);
    end

    assign status.mode = item_reg.mode;
    assign status.last_center = ({1'b0, idx_reg} + (IdxW+1)'(1)) == lim;
    assign status.div_last = bit_reg == 6'd0;
    assign status.count_zero = n_cnt == '0;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            new_cen[k] = (quo_reg[k] > QuotW'(16'hFFFF)) ? 16'hFFFF : quo_reg[k][CenW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [CntW:0] r;
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        if (cmd.dist_start)
        begin
            idx_reg <= '0;
            best_reg <= '0;
        end
        if (cmd.dist_step)
        begin
            if (idx_reg == '0 || d_sum < best_d_reg)
            begin
                best_d_reg <= d_sum;
                best_reg <= idx_reg;
            end
            idx_reg <= idx_reg + IdxW'(1);
        end
        if (cmd.div_start)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= {sum_reg[k][item_reg.slot], 8'd0} + QuotW'(n_cnt >> 1);
                quo_reg[k] <= '0;
                rem_reg[k] <= '0;
            end
            bit_reg <= 6'(QuotW - 1);
        end
        if (cmd.div_step)
        begin
            for (int k = 0; k < 3; k++)
            begin
                r = {rem_reg[k][CntW-1:0], num_reg[k][bit_reg]};
                if (r >= {1'b0, n_cnt})
                begin
                    rem_reg[k] <= r - {1'b0, n_cnt};
                    quo_reg[k][bit_reg] <= 1'b1;
                end
                else
                begin
                    rem_reg[k] <= r;
                end
            end
            bit_reg <= bit_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        out_item_t res_v;
        if (!rst_n)
        begin
            for (int i = 0; i < MaxCenters; i++)
            begin
                cnt_reg[i] <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    cen_reg[k][i] <= '0;
                    sum_reg[k][i] <= '0;
                end
            end
            res_reg <= '0;
            empty_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accumulate)
            begin
                if (cnt_reg[best_reg] < CntW'(MaxPixels))
                begin
                    cnt_reg[best_reg] <= cnt_reg[best_reg] + CntW'(1);
                    for (int k = 0; k < 3; k++)
                    begin
                        sum_reg[k][best_reg] <= sum_reg[k][best_reg] + SumW'(pix[k]);
                    end
                end
                res_v = '0;
                res_v.cluster_index = best_reg;
                res_v.min_distance_sq = best_d_reg;
                res_reg <= res_v;
            end
            if (cmd.update_write)
            begin
                res_v = '0;
                res_v.cluster_index = item_reg.slot;
                if (item_reg.mode == ModeLoad)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        cen_reg[k][item_reg.slot] <= {pix[k], 8'd0};
                    end
                end
                else if (item_reg.mode == ModeRead)
                begin
                    res_v.center_y = round_center(cur_cen[0]);
                    res_v.center_cb = round_center(cur_cen[1]);
                    res_v.center_cr = round_center(cur_cen[2]);
                end
                else if (item_reg.mode == ModeUpdate)
                begin
                    cnt_reg[item_reg.slot] <= '0;
                    for (int k = 0; k < 3; k++)
                    begin
                        sum_reg[k][item_reg.slot] <= '0;
                    end
                    if (n_cnt == '0)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            cen_reg[k][item_reg.slot] <= {pix[k], 8'd0};
                        end
                        res_v.center_y = pix[0];
                        res_v.center_cb = pix[1];
                        res_v.center_cr = pix[2];
                        res_v.was_empty = 1'b1;
                    end
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            cen_reg[k][item_reg.slot] <= new_cen[k];
                        end
                        res_v.center_y = round_center(new_cen[0]);
                        res_v.center_cb = round_center(new_cen[1]);
                        res_v.center_cr = round_center(new_cen[2]);
                    end
                end
                res_reg <= res_v;
            end
            empty_reg <= cmd.finish;
        end
    end

    always_comb
    begin
        out_item = res_reg;
        if (empty_reg && 1'b0)
        begin
            out_item = '0;
        end
    end
endmodule
`default_nettype wire

>>> rtl/kmeans_color_palette_engine_top.sv
// Sequence: load, read and empty update go through capture, write and output; pixel items also
// search every active center and accumulate; updates with members run the divider and store.
// Throughput: one item at a time, bounded by the center search and the bit-serial divider.
// Reset clears all centers, sums and counts and sets active_centers to 16.
// ----------------------------------------------------------------------------
// kmeans_color_palette_engine_top
// Lloyd k-means palette engine over YCbCr pixels.
// ----------------------------------------------------------------------------
`default_nettype none
module kmeans_color_palette_engine_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  kcp_pkg::in_item_t        in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output kcp_pkg::out_item_t       out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [4:0]          cfg_data
);
    import kcp_pkg::*;

    logic [4:0] active_reg;
    cmd_t       cmd;
    status_t    status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 5'(MaxCenters);
        end
        else if (cfg_valid)
        begin
            active_reg <= cfg_data;
        end
    end

    kcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .cmd      (cmd)
    );

    kcp_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_item        (in_data),
        .active_centers (active_reg),
        .cmd            (cmd),
        .status         (status),
        .out_item       (out_data)
    );
endmodule
`default_nettype wire

>>> rtl/kcp_checker.sv
// ----------------------------------------------------------------------------
// kcp_checker
// Port-level checks on the palette engine handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kmeans_color_palette_engine_top_defines.svh"
module kcp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input kcp_pkg::out_item_t      out_data
);
    import kcp_pkg::*;

    `KCP_ASSERT_IMPL(a_not_both, clk, rst_n, out_valid, in_stall)
    `KCP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `KCP_ASSERT_NEXT(a_free, clk, rst_n, out_valid && !out_stall, !out_valid && !in_stall)
    `KCP_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall && !out_valid)
endmodule

bind kmeans_color_palette_engine_top kcp_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);
`default_nettype wire
